/* rtl/byte_ring_fifo_peek_defines.svh */
// Assertion macros shared by the byte ring FIFO checker.
`ifndef BYTE_RING_FIFO_PEEK_DEFINES_SVH
`define BYTE_RING_FIFO_PEEK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/brfp_pkg.sv */
// Shared types and constants of the byte ring FIFO with peek.
`default_nettype none

package brfp_pkg;

  // Store geometry
  localparam int unsigned CAPACITY   = 4096;
  localparam int unsigned PTR_W      = $clog2(CAPACITY);
  localparam int unsigned MAX_BYTES  = 8;
  localparam int unsigned NUM_BANKS  = 8;
  localparam int unsigned BANK_W     = $clog2(NUM_BANKS);
  localparam int unsigned ROW_W      = PTR_W - BANK_W;
  localparam int unsigned BANK_DEPTH = CAPACITY / NUM_BANKS;

  // Field widths
  localparam int unsigned TYPE_W   = 2;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned FILL_W   = 13;
  localparam int unsigned S_TDATA_W = 96;
  localparam int unsigned M_TDATA_W = 80;

  typedef enum logic [TYPE_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_SKIP  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_req;
    logic exec;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/brfp_ctrl.sv */
// Sequencing state machine of the byte ring FIFO.
`default_nettype none

module brfp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_ready_o,
  input  brfp_pkg::stat_t     stat_i,
  output brfp_pkg::cmd_t      cmd_o
);

  brfp_pkg::state_e state_q, state_d;

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brfp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance through accept, execute and respond
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      brfp_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = brfp_pkg::S_EXEC;
        end
      end
      brfp_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = brfp_pkg::S_RESP;
      end
      brfp_pkg::S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = brfp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = brfp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/brfp_dpath.sv */
// Banked byte store, pointers, fill count and result register.
`default_nettype none

module brfp_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  brfp_pkg::cmd_t                         cmd_i,
  input  wire logic [brfp_pkg::TYPE_W-1:0]       req_type_i,
  input  wire logic [brfp_pkg::COUNT_W-1:0]      byte_count_i,
  input  wire logic [brfp_pkg::OFFSET_W-1:0]     peek_offset_i,
  input  wire logic [brfp_pkg::DATA_W-1:0]       write_data_i,
  input  wire logic                              out_ready_i,
  output brfp_pkg::stat_t                        stat_o,
  output logic                                   out_valid_o,
  output logic [brfp_pkg::DATA_W-1:0]            read_data_o,
  output logic                                   ok_o,
  output logic [brfp_pkg::FILL_W-1:0]            fill_level_o
);

  localparam int unsigned CMP_W = brfp_pkg::FILL_W + 1;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(brfp_pkg::CAPACITY);
  localparam logic [brfp_pkg::COUNT_W-1:0] MAX_C = brfp_pkg::COUNT_W'(brfp_pkg::MAX_BYTES);

  // Request registers
  brfp_pkg::req_type_e                 req_type_q;
  logic [brfp_pkg::COUNT_W-1:0]        count_q;
  logic [brfp_pkg::OFFSET_W-1:0]       offset_q;
  logic [brfp_pkg::DATA_W-1:0]         wdata_q;

  // FIFO state
  logic [brfp_pkg::PTR_W-1:0]          rd_ptr_q, rd_ptr_d;
  logic [brfp_pkg::PTR_W-1:0]          wr_ptr_q, wr_ptr_d;
  logic [brfp_pkg::FILL_W-1:0]         fill_q, fill_d;

  // Execute results kept for the response
  logic                                ok_q, ok_d;
  logic [brfp_pkg::BANK_W-1:0]         start_lo_q;

  // Result register
  logic                                out_valid_q;
  logic [brfp_pkg::DATA_W-1:0]         rdata_out_q, rdata_d;
  logic                                ok_out_q;
  logic [brfp_pkg::FILL_W-1:0]         fill_out_q;

  // Bank ports
  logic [brfp_pkg::PTR_W-1:0]          start_pos;
  logic [brfp_pkg::ROW_W-1:0]          start_row;
  logic [brfp_pkg::BANK_W-1:0]         start_lo;
  logic                                count_ok;
  logic                                is_data_rd;
  logic [brfp_pkg::ROW_W-1:0]          bank_addr  [brfp_pkg::NUM_BANKS];
  logic                                bank_we    [brfp_pkg::NUM_BANKS];
  logic [7:0]                          bank_wdata [brfp_pkg::NUM_BANKS];
  logic [7:0]                          bank_rdata [brfp_pkg::NUM_BANKS];

  // Latch the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_type_q <= brfp_pkg::req_type_e'(req_type_i);
      count_q    <= byte_count_i;
      offset_q   <= peek_offset_i;
      wdata_q    <= write_data_i;
    end
  end

  // Check the request against count limits, free space and fill level
  assign count_ok   = (count_q != '0) && (count_q <= MAX_C);
  assign is_data_rd = (req_type_q == brfp_pkg::REQ_READ) || (req_type_q == brfp_pkg::REQ_PEEK);

  always_comb begin
    unique case (req_type_q)
      brfp_pkg::REQ_WRITE: ok_d = count_ok &&
                                  ({1'b0, count_q} <= (CAP_C - {1'b0, fill_q}));
      brfp_pkg::REQ_READ:  ok_d = count_ok && (count_q <= fill_q);
      brfp_pkg::REQ_PEEK:  ok_d = count_ok &&
                                  ((CMP_W'(offset_q) + CMP_W'(count_q)) <= {1'b0, fill_q});
      brfp_pkg::REQ_SKIP:  ok_d = (count_q <= fill_q);
      default:             ok_d = 1'b0;
    endcase
  end

  // First byte position: write point, or read point plus peek offset
  always_comb begin
    if (req_type_q == brfp_pkg::REQ_WRITE) begin
      start_pos = wr_ptr_q;
    end else if (req_type_q == brfp_pkg::REQ_PEEK) begin
      start_pos = rd_ptr_q + brfp_pkg::PTR_W'(offset_q);
    end else begin
      start_pos = rd_ptr_q;
    end
  end

  assign start_lo  = start_pos[brfp_pkg::BANK_W-1:0];
  assign start_row = start_pos[brfp_pkg::PTR_W-1:brfp_pkg::BANK_W];

  // Address each bank: banks below the start byte take the next row
  for (genvar b = 0; b < brfp_pkg::NUM_BANKS; b++) begin : g_bank
    logic [7:0]                  mem [brfp_pkg::BANK_DEPTH];
    logic [brfp_pkg::BANK_W-1:0] lane;
    logic                        re;

    assign lane          = brfp_pkg::BANK_W'(b) - start_lo;
    assign bank_addr[b]  = start_row + brfp_pkg::ROW_W'(brfp_pkg::BANK_W'(b) < start_lo);
    assign bank_we[b]    = cmd_i.exec && ok_d && (req_type_q == brfp_pkg::REQ_WRITE) &&
                           (brfp_pkg::COUNT_W'(lane) < count_q);
    assign bank_wdata[b] = wdata_q[8*lane +: 8];
    assign re            = cmd_i.exec && is_data_rd;

    // Write or read one byte of this bank
    always_ff @(posedge clk_i) begin
      if (bank_we[b]) begin
        mem[bank_addr[b]] <= bank_wdata[b];
      end
      if (re) begin
        bank_rdata[b] <= mem[bank_addr[b]];
      end
    end
  end

  // Advance pointers and fill count on an accepted request
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    if (ok_d) begin
      unique case (req_type_q)
        brfp_pkg::REQ_WRITE: begin
          wr_ptr_d = wr_ptr_q + brfp_pkg::PTR_W'(count_q);
          fill_d   = fill_q + count_q;
        end
        brfp_pkg::REQ_READ, brfp_pkg::REQ_SKIP: begin
          rd_ptr_d = rd_ptr_q + brfp_pkg::PTR_W'(count_q);
          fill_d   = fill_q - count_q;
        end
        brfp_pkg::REQ_PEEK: begin
          fill_d = fill_q;
        end
        default: begin
          fill_d = fill_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else if (cmd_i.exec) begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q       <= ok_d;
      start_lo_q <= start_lo;
    end
  end

  // Rotate bank outputs into little-endian order and mask unused bytes
  always_comb begin
    logic [brfp_pkg::BANK_W-1:0] sel;
    rdata_d = '0;
    for (int i = 0; i < brfp_pkg::NUM_BANKS; i++) begin
      sel = start_lo_q + brfp_pkg::BANK_W'(i);
      if (ok_q && is_data_rd && (brfp_pkg::COUNT_W'(i) < count_q)) begin
        rdata_d[8*i +: 8] = bank_rdata[sel];
      end
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rdata_out_q <= rdata_d;
      ok_out_q    <= ok_q;
      fill_out_q  <= fill_q;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rdata_out_q;
  assign ok_o            = ok_out_q;
  assign fill_level_o    = fill_out_q;

endmodule

`default_nettype wire

/* rtl/byte_ring_fifo_peek.sv */
// Top level of the byte ring FIFO with peek.
// A 4096-byte circular FIFO held in eight byte-wide banks, so any run of up
// to eight consecutive bytes is one access per bank. Each input beat is a
// write (1-8 bytes), read (1-8 bytes, consumed), peek (1-8 bytes at an
// offset, not consumed) or skip (any count up to the fill level); one result
// beat answers each, with ok low and the state untouched when the request
// does not fit. A request goes through accept, bank access with the
// pointer update, and loading the result register, which waits while an
// untaken result is held; a new beat is accepted only once the last one
// has loaded its result. The result register lets the next beat be
// accepted while a result still waits. Bytes are packed little-endian. The
// store has no reset; only held bytes are ever returned.
`default_nettype none

module byte_ring_fifo_peek (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // s_tdata: byte_count[12:0], peek_offset[24:13], write_data[88:25], zero pad
  input  wire logic [brfp_pkg::S_TDATA_W-1:0]        s_tdata,
  // s_tuser: req_type[1:0]
  input  wire logic [brfp_pkg::TYPE_W-1:0]           s_tuser,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // m_tdata: read_data[63:0], fill_level[76:64], zero pad
  output logic [brfp_pkg::M_TDATA_W-1:0]             m_tdata,
  // m_tuser: ok[0]
  output logic [0:0]                                 m_tuser,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready
);

  localparam int unsigned OFF_LO  = brfp_pkg::COUNT_W;
  localparam int unsigned DATA_LO = brfp_pkg::COUNT_W + brfp_pkg::OFFSET_W;
  localparam int unsigned PAD_W   = brfp_pkg::M_TDATA_W - brfp_pkg::DATA_W - brfp_pkg::FILL_W;

  brfp_pkg::cmd_t                 cmd;
  brfp_pkg::stat_t                stat;
  logic [brfp_pkg::DATA_W-1:0]    read_data;
  logic                           ok;
  logic [brfp_pkg::FILL_W-1:0]    fill_level;

  brfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_tvalid),
    .req_ready_o (s_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  brfp_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (s_tuser),
    .byte_count_i  (s_tdata[OFF_LO-1:0]),
    .peek_offset_i (s_tdata[DATA_LO-1:OFF_LO]),
    .write_data_i  (s_tdata[DATA_LO+brfp_pkg::DATA_W-1:DATA_LO]),
    .out_ready_i   (m_tready),
    .stat_o        (stat),
    .out_valid_o   (m_tvalid),
    .read_data_o   (read_data),
    .ok_o          (ok),
    .fill_level_o  (fill_level)
  );

  // Pack the result beat
  assign m_tdata = {{PAD_W{1'b0}}, fill_level, read_data};
  assign m_tuser = ok;

endmodule

`default_nettype wire

/* rtl/brfp_chk.sv */
// Port-level checker of the byte ring FIFO, bound to the top level.
`default_nettype none
`include "byte_ring_fifo_peek_defines.svh"

module brfp_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic [brfp_pkg::M_TDATA_W-1:0]    m_tdata,
  input wire logic [0:0]                        m_tuser,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready
);

  localparam logic [brfp_pkg::FILL_W-1:0] CAP_C = brfp_pkg::FILL_W'(brfp_pkg::CAPACITY);

  logic [brfp_pkg::FILL_W-1:0] fill_seen;
  logic [brfp_pkg::DATA_W-1:0] data_seen;
  logic                        in_beat;

  assign fill_seen = m_tdata[brfp_pkg::DATA_W+brfp_pkg::FILL_W-1:brfp_pkg::DATA_W];
  assign data_seen = m_tdata[brfp_pkg::DATA_W-1:0];
  assign in_beat   = s_tvalid && s_tready;

  // A stalled result beat stays and holds its payload
  `BRFP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
  `BRFP_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result payload changed while stalled")

  // A rejected request returns no data
  `BRFP_ASSERT_IMP(a_reject_zero, clk_i, rst_ni, m_tvalid && !m_tuser[0], data_seen == '0, "rejected request returned data")

  // Fill level never exceeds the capacity
  `BRFP_ASSERT_IMP(a_fill_cap, clk_i, rst_ni, m_tvalid, fill_seen <= CAP_C, "fill level above capacity")

  // One request at a time: no accept in the cycle after an accept
  `BRFP_ASSERT_NXT(a_one_at_time, clk_i, rst_ni, in_beat, !s_tready, "input accepted while a request is in progress")

endmodule

bind byte_ring_fifo_peek brfp_chk u_brfp_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

`default_nettype wire

/* test/byte_ring_fifo_peek_tb.sv */
// Self-checking testbench for the byte ring FIFO with peek.
`timescale 1ns / 100ps

module byte_ring_fifo_peek_tb;
  import brfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned HOLD_LEN     = 300;
  localparam int unsigned PAD_W        = S_TDATA_W - COUNT_W - OFFSET_W - DATA_W;

  typedef struct {
    req_type_e            kind;
    logic [COUNT_W-1:0]   count;
    logic [OFFSET_W-1:0]  offset;
    logic [DATA_W-1:0]    wdata;
  } fifo_req_t;

  typedef struct {
    logic [DATA_W-1:0]    rdata;
    logic                 ok;
    logic [FILL_W-1:0]    fill;
  } fifo_resp_t;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic [S_TDATA_W-1:0]   s_tdata  = '0;
  logic [TYPE_W-1:0]      s_tuser  = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [0:0]             m_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;

  // Predicted FIFO contents and pointers
  logic [7:0]             ring_bytes [CAPACITY];
  int unsigned            rd_pos = 0;
  int unsigned            wr_pos = 0;
  int unsigned            held   = 0;

  fifo_req_t              req_backlog [$];
  fifo_resp_t             results_due [$];
  fifo_req_t              offered;
  int unsigned            plan_fill  = 0;
  int unsigned            mismatches = 0;
  int unsigned            in_beats   = 0;
  int unsigned            out_beats  = 0;
  int unsigned            send_gap   = 0;
  int unsigned            recv_gap   = 0;
  int unsigned            hold_left  = 0;
  bit                     hold_armed = 1'b1;
  bit                     idle_on    = 1'b1;
  int unsigned            cycle_count = 0;

  byte_ring_fifo_peek dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Serve one request against the predicted store and return its result
  function automatic fifo_resp_t serve_request(input fifo_req_t r);
    fifo_resp_t  resp;
    int unsigned n;
    int unsigned off;
    bit          span_ok;
    n       = r.count;
    off     = r.offset;
    span_ok = (n >= 1) && (n <= MAX_BYTES);
    resp.rdata = '0;
    resp.ok    = 1'b0;
    case (r.kind)
      REQ_WRITE: begin
        if (span_ok && n <= CAPACITY - held) begin
          for (int i = 0; i < n; i++) ring_bytes[(wr_pos + i) % CAPACITY] = r.wdata[8*i +: 8];
          wr_pos  = (wr_pos + n) % CAPACITY;
          held    = held + n;
          resp.ok = 1'b1;
        end
      end
      REQ_READ: begin
        if (span_ok && n <= held) begin
          for (int i = 0; i < n; i++) resp.rdata[8*i +: 8] = ring_bytes[(rd_pos + i) % CAPACITY];
          rd_pos  = (rd_pos + n) % CAPACITY;
          held    = held - n;
          resp.ok = 1'b1;
        end
      end
      REQ_PEEK: begin
        if (span_ok && off + n <= held) begin
          for (int i = 0; i < n; i++)
            resp.rdata[8*i +: 8] = ring_bytes[(rd_pos + off + i) % CAPACITY];
          resp.ok = 1'b1;
        end
      end
      default: begin
        if (n <= held) begin
          rd_pos  = (rd_pos + n) % CAPACITY;
          held    = held - n;
          resp.ok = 1'b1;
        end
      end
    endcase
    resp.fill = FILL_W'(held);
    return resp;
  endfunction

  // Queue one request and track the fill level it leaves, for steering the stimulus
  task automatic queue_request(input req_type_e kind, input int unsigned count,
                               input int unsigned offset, input logic [DATA_W-1:0] wdata);
    fifo_req_t   r;
    int unsigned n;
    r.kind   = kind;
    r.count  = COUNT_W'(count);
    r.offset = OFFSET_W'(offset);
    r.wdata  = wdata;
    n        = r.count;
    req_backlog.push_back(r);
    if (kind == REQ_WRITE && n >= 1 && n <= MAX_BYTES && n <= CAPACITY - plan_fill)
      plan_fill = plan_fill + n;
    else if (kind == REQ_READ && n >= 1 && n <= MAX_BYTES && n <= plan_fill)
      plan_fill = plan_fill - n;
    else if (kind == REQ_SKIP && n <= plan_fill)
      plan_fill = plan_fill - n;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly legal byte counts, sometimes zero, just too many, or anything
  function automatic int unsigned pick_data_count();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return $urandom_range(MAX_BYTES + 1, 15);
      2:       return $urandom_range(0, (1 << COUNT_W) - 1);
      default: return $urandom_range(1, MAX_BYTES);
    endcase
  endfunction

  function automatic int unsigned pick_offset();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, (1 << OFFSET_W) - 1);
    return $urandom_range(0, plan_fill > 4095 ? 4095 : plan_fill);
  endfunction

  function automatic int unsigned pick_skip_count();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, (1 << COUNT_W) - 1);
      1:       return plan_fill;
      default: return $urandom_range(0, plan_fill > 24 ? 24 : plan_fill);
    endcase
  endfunction

  task automatic queue_mixed(input int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        queue_request(REQ_WRITE, pick_data_count(), $urandom_range(0, 4095), rand_word());
      else if (pick < 6)
        queue_request(REQ_READ, pick_data_count(), $urandom_range(0, 4095), rand_word());
      else if (pick < 8)
        queue_request(REQ_PEEK, pick_data_count(), pick_offset(), rand_word());
      else
        queue_request(REQ_SKIP, pick_skip_count(), $urandom_range(0, 4095), rand_word());
    end
  endtask

  // Hold the sender until every beat has gone in and every result has come back
  task automatic wait_quiet();
    while (req_backlog.size() != 0 || s_tvalid || results_due.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h", out_beats, field, got, want);
    mismatches++;
  endtask

  // Drive request beats from the backlog, predicting each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      send_gap <= 0;
      in_beats <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        results_due.push_back(serve_request(offered));
        in_beats <= in_beats + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (idle_on && req_backlog.size() != 0 && $urandom_range(0, 11) == 0) begin
          send_gap <= $urandom_range(0, 12);
          s_tvalid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          offered  = req_backlog.pop_front();
          s_tdata  <= {{PAD_W{1'b0}}, offered.wdata, offered.offset, offered.count};
          s_tuser  <= offered.kind;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Count out one long receiver hold-off once enough beats have gone in
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && in_beats >= HOLD_AT) begin
      hold_left  <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Take result beats and check them against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    fifo_resp_t want;
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      recv_gap  <= 0;
      out_beats <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        out_beats <= out_beats + 1;
        if (results_due.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata[DATA_W-1:0], '0);
        end else begin
          want = results_due.pop_front();
          if (m_tdata[DATA_W-1:0] !== want.rdata)
            report_mismatch("read_data", m_tdata[DATA_W-1:0], want.rdata);
          if (m_tuser[0] !== want.ok)
            report_mismatch("ok", DATA_W'(m_tuser[0]), DATA_W'(want.ok));
          if (m_tdata[DATA_W +: FILL_W] !== want.fill)
            report_mismatch("fill_level", DATA_W'(m_tdata[DATA_W +: FILL_W]), DATA_W'(want.fill));
        end
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 12);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty store: underflow on every consuming or peeking request, zero skip
    queue_request(REQ_READ, 1, 0, '0);
    queue_request(REQ_PEEK, 1, 0, '0);
    queue_request(REQ_SKIP, 0, 0, '0);
    queue_request(REQ_SKIP, 1, 0, '0);
    // Byte counts out of range
    queue_request(REQ_WRITE, 0, 0, '1);
    queue_request(REQ_WRITE, 9, 0, '1);
    queue_request(REQ_WRITE, (1 << COUNT_W) - 1, 4095, '1);
    // Single, full-width and patterned writes
    queue_request(REQ_WRITE, 1, 0, 64'h0000_0000_0000_00A5);
    queue_request(REQ_WRITE, 8, 0, '1);
    queue_request(REQ_WRITE, 8, 0, 64'h0123_4567_89AB_CDEF);
    // Peeks up to the fill level and past it, then out-of-range peek and read counts
    queue_request(REQ_PEEK, 8, 0, '0);
    queue_request(REQ_PEEK, 8, 9, '0);
    queue_request(REQ_PEEK, 8, 10, '0);
    queue_request(REQ_PEEK, 8, 4095, '0);
    queue_request(REQ_PEEK, 0, 0, '0);
    queue_request(REQ_PEEK, 9, 0, '0);
    queue_request(REQ_READ, 0, 0, '0);
    queue_request(REQ_READ, 9, 0, '0);
    // Drain in steps, refill five bytes, underflow a read and a skip, then skip the rest
    queue_request(REQ_READ, 1, 0, '0);
    queue_request(REQ_READ, 8, 0, '0);
    queue_request(REQ_READ, 8, 0, '0);
    queue_request(REQ_WRITE, 5, 0, rand_word());
    queue_request(REQ_READ, 6, 0, '0);
    queue_request(REQ_SKIP, 6, 0, '0);
    queue_request(REQ_SKIP, 5, 0, '0);

    // Mixed traffic; the long receiver hold-off falls in here
    queue_mixed(30);
    wait_quiet();

    // Fill to capacity, mostly with full-width writes and the odd peek
    while (plan_fill < CAPACITY) begin
      if ($urandom_range(0, 15) == 0)
        queue_request(REQ_PEEK, $urandom_range(1, MAX_BYTES), pick_offset(), rand_word());
      else if (CAPACITY - plan_fill < MAX_BYTES)
        queue_request(REQ_WRITE, CAPACITY - plan_fill, 0, rand_word());
      else if ($urandom_range(0, 7) == 0)
        queue_request(REQ_WRITE, $urandom_range(1, MAX_BYTES), 0, rand_word());
      else
        queue_request(REQ_WRITE, MAX_BYTES, 0, rand_word());
    end

    // Full store: overflow, deepest peeks, wrap and a whole-store skip
    queue_request(REQ_WRITE, 1, 0, rand_word());
    queue_request(REQ_WRITE, 8, 0, rand_word());
    queue_request(REQ_PEEK, 1, 4095, '0);
    queue_request(REQ_PEEK, 8, 4088, '0);
    queue_request(REQ_PEEK, 8, 4089, '0);
    repeat (6) queue_request(REQ_PEEK, $urandom_range(1, MAX_BYTES), pick_offset(), rand_word());
    queue_request(REQ_SKIP, CAPACITY + 1, 0, '0);
    queue_request(REQ_READ, 8, 0, '0);
    queue_request(REQ_WRITE, 8, 0, rand_word());
    queue_request(REQ_WRITE, 1, 0, rand_word());
    queue_request(REQ_SKIP, CAPACITY, 0, '0);
    queue_request(REQ_WRITE, 3, 0, rand_word());
    queue_request(REQ_SKIP, CAPACITY, 0, '0);
    wait_quiet();

    // Closing stretch with both sides at full rate
    idle_on = 1'b0;
    queue_mixed(20);
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/brfp_pkg.sv
rtl/brfp_ctrl.sv
rtl/brfp_dpath.sv
rtl/byte_ring_fifo_peek.sv
rtl/brfp_chk.sv
test/byte_ring_fifo_peek_tb.sv
